FILE: rtl/dorr_pkg.sv
// Package for the diff operation region reorder unit: field widths, command
// and kind codes, default parameters and the position-control struct.
// No dependencies.
`default_nettype none
package dorr_pkg;

	localparam int REGION_DEPTH_DEF = 32;
	localparam int LINE_BITS_DEF    = 24;
	localparam int COLUMN_BITS_DEF  = 16;

	localparam int CMD_BITS   = 2;
	localparam int KIND_BITS  = 2;
	localparam int CODE_BITS  = 21;
	localparam int START_BITS = 24;
	// buffered entry: insert flag above the character code
	localparam int ENTRY_BITS = CODE_BITS + 1;

	localparam logic [CMD_BITS-1:0] CMD_START = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_EDIT  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_END   = 2'd2;

	localparam logic [KIND_BITS-1:0] KIND_KEEP   = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd2;

	localparam logic [CODE_BITS-1:0] NEWLINE_CODE = 21'd10;

	typedef struct packed {
		logic                  load;
		logic [START_BITS-1:0] load_line;
		logic                  step;
		logic [KIND_BITS-1:0]  kind;
		logic                  newline;
	} dorr_pos_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/dorr_if.sv
// Request channels of the reorder unit: operation input and result output.
// Depends on dorr_pkg.
`default_nettype none
interface dorr_in_if;
	import dorr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CMD_BITS-1:0]   cmd;
	logic [KIND_BITS-1:0]  op_kind;
	logic [CODE_BITS-1:0]  char_code;
	logic [START_BITS-1:0] start_line;

	modport source (output valid, cmd, op_kind, char_code, start_line, input ready);
	modport sink   (input valid, cmd, op_kind, char_code, start_line, output ready);
endinterface

interface dorr_out_if #(
	parameter int LINE_BITS   = dorr_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = dorr_pkg::COLUMN_BITS_DEF
);
	import dorr_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [KIND_BITS-1:0]   out_kind;
	logic [CODE_BITS-1:0]   out_code;
	logic [LINE_BITS-1:0]   line_number;
	logic [COLUMN_BITS-1:0] column_number;
	logic                   last_of_run;
	logic                   region_split;

	modport source (output valid, out_kind, out_code, line_number, column_number,
		last_of_run, region_split, input ready);
	modport sink   (input valid, out_kind, out_code, line_number, column_number,
		last_of_run, region_split, output ready);
endinterface
`default_nettype wire

FILE: rtl/dorr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dorr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

FILE: rtl/dorr_pos.sv
// Line and column tracker: loads the hunk start, steps per emitted operation,
// saturating at the field maximum. Depends on dorr_pkg.
`default_nettype none
module dorr_pos #(
	parameter int LINE_BITS   = dorr_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = dorr_pkg::COLUMN_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire dorr_pkg::dorr_pos_ctl_t ctl,
	output logic [LINE_BITS-1:0]         line_q,
	output logic [COLUMN_BITS-1:0]       column_q
);
	import dorr_pkg::*;

	localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
	localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;
	localparam logic [LINE_BITS-1:0]   LINE_ONE   = LINE_BITS'(1);
	localparam logic [COLUMN_BITS-1:0] COLUMN_ONE = COLUMN_BITS'(1);

	logic [LINE_BITS-1:0] start_sat;

	generate
		if (LINE_BITS >= START_BITS) begin : g_wide
			assign start_sat = LINE_BITS'(ctl.load_line);
		end else begin : g_narrow
			assign start_sat = (|ctl.load_line[START_BITS-1:LINE_BITS]) ? LINE_MAX
				: ctl.load_line[LINE_BITS-1:0];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= LINE_ONE;
			column_q <= COLUMN_ONE;
		end else if (ctl.load) begin
			line_q   <= start_sat;
			column_q <= COLUMN_ONE;
		end else if (ctl.step) begin
			if (ctl.newline) begin
				if (line_q != LINE_MAX) begin
					line_q <= line_q + LINE_ONE;
				end
				column_q <= COLUMN_ONE;
			end else if (ctl.kind == KIND_KEEP || ctl.kind == KIND_INSERT) begin
				if (column_q != COLUMN_MAX) begin
					column_q <= column_q + COLUMN_ONE;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/dorr_ctrl.sv
// Sequencer of the reorder unit: buffers runs in the region RAM, replays them
// in a delete pass and an insert pass, and holds the result register.
// Depends on dorr_pkg and dorr_if.
`default_nettype none
module dorr_ctrl #(
	parameter int REGION_DEPTH = dorr_pkg::REGION_DEPTH_DEF,
	parameter int LINE_BITS    = dorr_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS  = dorr_pkg::COLUMN_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	dorr_in_if.sink                              ops,
	dorr_out_if.source                           results,
	output logic                                 wr_en,
	output logic [$clog2(REGION_DEPTH)-1:0]      wr_addr,
	output logic [dorr_pkg::ENTRY_BITS-1:0]      wr_data,
	output logic [$clog2(REGION_DEPTH)-1:0]      rd_addr,
	input  wire logic [dorr_pkg::ENTRY_BITS-1:0] rd_data,
	output dorr_pkg::dorr_pos_ctl_t              pos_ctl,
	input  wire logic [LINE_BITS-1:0]            line,
	input  wire logic [COLUMN_BITS-1:0]          column
);
	import dorr_pkg::*;

	localparam int AW = $clog2(REGION_DEPTH);
	localparam int CW = $clog2(REGION_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(REGION_DEPTH);
	localparam logic [CW-1:0] ONE  = CW'(1);

	typedef enum logic [1:0] {S_IDLE, S_FLUSH, S_EMIT} state_t;

	state_t                state_q;
	logic                  hunk_q;
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         del_cnt_q;
	logic [CW-1:0]         ins_cnt_q;
	logic                  pass_q;
	logic [CW-1:0]         rem_q;
	logic [AW-1:0]         idx_q;
	logic                  split_q;
	logic                  trail_q;
	logic                  wr_pend_q;
	logic                  ld_pend_q;
	logic [START_BITS-1:0] start_q;
	logic [KIND_BITS-1:0]  op_kind_q;
	logic [CODE_BITS-1:0]  op_code_q;

	logic                   out_valid_q;
	logic [KIND_BITS-1:0]   out_kind_q;
	logic [CODE_BITS-1:0]   out_code_q;
	logic [LINE_BITS-1:0]   out_line_q;
	logic [COLUMN_BITS-1:0] out_col_q;
	logic                   out_last_q;
	logic                   out_split_q;

	logic accept, is_edit, anchor, buffer_op, has_run, full;
	logic out_free, in_flush, ent_ins, match, hold;
	logic emit_flush, pass_end, to_second, flush_done, emit_trail, load_now;
	logic wr_buf, wr_late;
	logic [CODE_BITS-1:0] ent_code;

	assign ops.ready = (state_q == S_IDLE);
	assign accept    = ops.valid && ops.ready;
	assign is_edit   = ops.cmd == CMD_EDIT && hunk_q &&
		(ops.op_kind == KIND_KEEP || ops.op_kind == KIND_DELETE ||
		 ops.op_kind == KIND_INSERT);
	assign anchor    = is_edit && (ops.op_kind == KIND_KEEP || ops.char_code == NEWLINE_CODE);
	assign buffer_op = is_edit && !anchor;
	assign has_run   = hunk_q && fill_q != '0;
	assign full      = fill_q == FULL;
	assign load_now  = accept && ops.cmd == CMD_START && !has_run;

	assign ent_ins    = rd_data[ENTRY_BITS-1];
	assign ent_code   = rd_data[CODE_BITS-1:0];
	assign out_free   = !out_valid_q || results.ready;
	assign in_flush   = state_q == S_FLUSH;
	assign match      = ent_ins == pass_q;
	assign hold       = in_flush && match && !out_free;
	assign emit_flush = in_flush && match && out_free;
	assign pass_end   = emit_flush && rem_q == ONE;
	assign to_second  = pass_end && !pass_q && ins_cnt_q != '0;
	assign flush_done = pass_end && !to_second;
	assign emit_trail = state_q == S_EMIT && out_free;

	// re-read the same entry while the result register is stalled
	always_comb begin
		if (hold) begin
			rd_addr = idx_q;
		end else if (in_flush && !to_second) begin
			rd_addr = idx_q + AW'(1);
		end else begin
			rd_addr = '0;
		end
	end

	assign wr_buf  = accept && buffer_op && !full;
	assign wr_late = flush_done && wr_pend_q;
	assign wr_en   = wr_buf || wr_late;
	always_comb begin
		if (wr_late) begin
			wr_addr = '0;
			wr_data = {op_kind_q == KIND_INSERT, op_code_q};
		end else begin
			wr_addr = fill_q[AW-1:0];
			wr_data = {ops.op_kind == KIND_INSERT, ops.char_code};
		end
	end

	always_comb begin
		pos_ctl.load      = load_now || (flush_done && ld_pend_q);
		pos_ctl.load_line = load_now ? ops.start_line : start_q;
		pos_ctl.step      = emit_flush || emit_trail;
		if (emit_flush) begin
			pos_ctl.kind    = pass_q ? KIND_INSERT : KIND_DELETE;
			pos_ctl.newline = ent_code == NEWLINE_CODE;
		end else begin
			pos_ctl.kind    = op_kind_q;
			pos_ctl.newline = op_code_q == NEWLINE_CODE;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.out_kind      = out_kind_q;
	assign results.out_code      = out_code_q;
	assign results.line_number   = out_line_q;
	assign results.column_number = out_col_q;
	assign results.last_of_run   = out_last_q;
	assign results.region_split  = out_split_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hunk_q      <= 1'b0;
			fill_q      <= '0;
			del_cnt_q   <= '0;
			ins_cnt_q   <= '0;
			pass_q      <= 1'b0;
			rem_q       <= '0;
			idx_q       <= '0;
			split_q     <= 1'b0;
			trail_q     <= 1'b0;
			wr_pend_q   <= 1'b0;
			ld_pend_q   <= 1'b0;
			start_q     <= '0;
			op_kind_q   <= KIND_KEEP;
			op_code_q   <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_KEEP;
			out_code_q  <= '0;
			out_line_q  <= '0;
			out_col_q   <= '0;
			out_last_q  <= 1'b0;
			out_split_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_kind_q <= ops.op_kind;
						op_code_q <= ops.char_code;
						start_q   <= ops.start_line;
						split_q   <= 1'b0;
						trail_q   <= 1'b0;
						wr_pend_q <= 1'b0;
						ld_pend_q <= 1'b0;
						pass_q    <= del_cnt_q == '0;
						rem_q     <= (del_cnt_q == '0) ? ins_cnt_q : del_cnt_q;
						idx_q     <= '0;
						priority if (ops.cmd == CMD_START) begin
							hunk_q <= 1'b1;
							if (has_run) begin
								ld_pend_q <= 1'b1;
								state_q   <= S_FLUSH;
							end
						end else if (ops.cmd == CMD_END) begin
							hunk_q <= 1'b0;
							if (has_run) begin
								state_q <= S_FLUSH;
							end
						end else if (anchor) begin
							trail_q <= 1'b1;
							state_q <= (fill_q != '0) ? S_FLUSH : S_EMIT;
						end else if (buffer_op) begin
							if (full) begin
								split_q   <= 1'b1;
								wr_pend_q <= 1'b1;
								state_q   <= S_FLUSH;
							end else begin
								fill_q <= fill_q + ONE;
								if (ops.op_kind == KIND_INSERT) begin
									ins_cnt_q <= ins_cnt_q + ONE;
								end else begin
									del_cnt_q <= del_cnt_q + ONE;
								end
							end
						end else begin
							// drop: outside a hunk, unknown kind or unknown command
						end
					end
				end
				S_FLUSH: begin
					if (!hold) begin
						idx_q <= idx_q + AW'(1);
					end
					if (to_second) begin
						pass_q <= 1'b1;
						rem_q  <= ins_cnt_q;
						idx_q  <= '0;
					end else if (flush_done) begin
						fill_q    <= wr_pend_q ? ONE : '0;
						del_cnt_q <= (wr_pend_q && op_kind_q != KIND_INSERT) ? ONE : '0;
						ins_cnt_q <= (wr_pend_q && op_kind_q == KIND_INSERT) ? ONE : '0;
						wr_pend_q <= 1'b0;
						ld_pend_q <= 1'b0;
						state_q   <= trail_q ? S_EMIT : S_IDLE;
					end else if (emit_flush) begin
						rem_q <= rem_q - ONE;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (emit_flush) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= pass_q ? KIND_INSERT : KIND_DELETE;
				out_code_q  <= ent_code;
				out_line_q  <= line;
				out_col_q   <= column;
				out_last_q  <= flush_done && !trail_q;
				out_split_q <= split_q;
			end else if (emit_trail) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= op_kind_q;
				out_code_q  <= op_code_q;
				out_line_q  <= line;
				out_col_q   <= column;
				out_last_q  <= 1'b1;
				out_split_q <= 1'b0;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL)
		else $error("region fill beyond buffer depth");

	a_fill_counts: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == CW'(del_cnt_q + ins_cnt_q))
		else $error("region fill disagrees with kind counts");

	a_flush_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FLUSH |-> rem_q != '0)
		else $error("flush pass running with nothing left to emit");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !accept) |=> state_q == S_IDLE)
		else $error("sequencer left idle without a request");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_flush || emit_trail) |-> out_free)
		else $error("result register loaded while still occupied");
endmodule
`default_nettype wire

FILE: rtl/diff_op_region_reorder_unit.sv
// Diff operation region reorder unit. Takes one edit-operation request per
// accepted cycle on the ops channel and gives results on the results channel.
// Keep and newline operations are anchors; the deletes and inserts between two
// anchors are buffered in the region RAM (REGION_DEPTH entries) and replayed
// deletes first, then inserts, each in arrival order, before the anchor itself
// or at hunk end/start. Line and column are recomputed in output order and
// saturate at their maximum. A request that flushes a run is accepted, then
// the delete pass reads each entry up to the last delete and the insert pass
// each entry up to the last insert, through the single RAM read port, and the
// anchor itself, if any, comes out last. No new request is taken until the
// flush is done. A stalled results channel holds the replay on the current
// entry.
// No clearing pass after reset: only entries below the fill count are read.
// Depends on dorr_pkg, dorr_if, dorr_ram, dorr_pos and dorr_ctrl.
`default_nettype none
module diff_op_region_reorder_unit #(
	parameter int REGION_DEPTH = dorr_pkg::REGION_DEPTH_DEF,
	parameter int LINE_BITS    = dorr_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS  = dorr_pkg::COLUMN_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	dorr_in_if.sink    ops,
	dorr_out_if.source results
);
	import dorr_pkg::*;

	localparam int AW = $clog2(REGION_DEPTH);

	// region RAM port signals
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [ENTRY_BITS-1:0] wr_data;
	logic [AW-1:0]         rd_addr;
	logic [ENTRY_BITS-1:0] rd_data;

	// position tracker
	dorr_pos_ctl_t          pos_ctl;
	logic [LINE_BITS-1:0]   line;
	logic [COLUMN_BITS-1:0] column;

	// sequencer: accepts requests, fills and replays the region RAM
	dorr_ctrl #(
		.REGION_DEPTH (REGION_DEPTH),
		.LINE_BITS    (LINE_BITS),
		.COLUMN_BITS  (COLUMN_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.ops     (ops),
		.results (results),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.pos_ctl (pos_ctl),
		.line    (line),
		.column  (column)
	);

	// buffered run: insert flag and character code per entry
	dorr_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (REGION_DEPTH)
	) u_region_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// line and column in output order; stepped on every emitted result
	dorr_pos #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pos_ctl),
		.line_q   (line),
		.column_q (column)
	);
endmodule
`default_nettype wire

FILE: tb/dorr_reorder_checker.sv
// Result checker for the diff operation region reorder unit: predicts the
// reordered result stream from every accepted request and checks each result.
// Depends on dorr_pkg and dorr_if.
`default_nettype none
module dorr_reorder_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	dorr_in_if        ops,
	dorr_out_if       results,
	output int        mismatches,
	output int        pending_results,
	output int        results_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import dorr_pkg::*;

	localparam int REPORT_LIMIT = 20;
	localparam logic [LINE_BITS_DEF-1:0]   LINE_MAX   = '1;
	localparam logic [COLUMN_BITS_DEF-1:0] COLUMN_MAX = '1;

	typedef struct packed {
		logic [KIND_BITS-1:0]       kind;
		logic [CODE_BITS-1:0]       code;
		logic [LINE_BITS_DEF-1:0]   line;
		logic [COLUMN_BITS_DEF-1:0] column;
		logic                       last;
		logic                       split;
	} reorder_result_t;

	reorder_result_t expected_ops [$];

	// predicted state of the block
	logic [ENTRY_BITS-1:0]      run_store [REGION_DEPTH_DEF];
	int                         run_fill    = 0;
	logic [LINE_BITS_DEF-1:0]   pred_line   = LINE_BITS_DEF'(1);
	logic [COLUMN_BITS_DEF-1:0] pred_column = COLUMN_BITS_DEF'(1);
	logic                       in_hunk     = 1'b0;

	int fail_total    = 0;
	int checked_total = 0;
	int waiting       = 0;

	assign mismatches      = fail_total;
	assign pending_results = waiting;
	assign results_checked = checked_total;

	// Queue one result at the current position, then advance the position.
	task automatic place_op(input logic [KIND_BITS-1:0] kind,
		input logic [CODE_BITS-1:0] code, input logic split);
		reorder_result_t r;
		r.kind   = kind;
		r.code   = code;
		r.line   = pred_line;
		r.column = pred_column;
		r.last   = 1'b0;
		r.split  = split;
		expected_ops.push_back(r);
		if (code == NEWLINE_CODE) begin
			if (pred_line != LINE_MAX)
				pred_line = pred_line + 1'b1;
			pred_column = COLUMN_BITS_DEF'(1);
		end else if (kind == KIND_KEEP || kind == KIND_INSERT) begin
			if (pred_column != COLUMN_MAX)
				pred_column = pred_column + 1'b1;
		end
	endtask

	// Deletes first, then inserts, each in arrival order.
	task automatic replay_run(input logic split);
		for (int pass = 0; pass < 2; pass++)
			for (int i = 0; i < run_fill; i++)
				if (run_store[i][CODE_BITS] == pass[0])
					place_op(run_store[i][CODE_BITS] ? KIND_INSERT : KIND_DELETE,
						run_store[i][CODE_BITS-1:0], split);
		run_fill = 0;
	endtask

	task automatic predict_request(input logic [CMD_BITS-1:0] cmd,
		input logic [KIND_BITS-1:0] kind, input logic [CODE_BITS-1:0] code,
		input logic [START_BITS-1:0] start);
		int queued_prior;
		reorder_result_t tail;
		queued_prior = expected_ops.size();
		case (cmd)
			CMD_START: begin
				if (in_hunk)
					replay_run(1'b0);
				run_fill    = 0;
				// start line is as wide as the line counter: no saturation
				pred_line   = start;
				pred_column = COLUMN_BITS_DEF'(1);
				in_hunk     = 1'b1;
			end
			CMD_EDIT: begin
				if (in_hunk && (kind == KIND_KEEP || kind == KIND_DELETE ||
						kind == KIND_INSERT)) begin
					if (kind == KIND_KEEP || code == NEWLINE_CODE) begin
						replay_run(1'b0);
						place_op(kind, code, 1'b0);
					end else begin
						if (run_fill >= REGION_DEPTH_DEF)
							replay_run(1'b1);
						run_store[run_fill] = {kind == KIND_INSERT, code};
						run_fill++;
					end
				end
			end
			CMD_END: begin
				if (in_hunk)
					replay_run(1'b0);
				run_fill = 0;
				in_hunk  = 1'b0;
			end
			default: ;
		endcase
		if (expected_ops.size() > queued_prior) begin
			tail = expected_ops.pop_back();
			tail.last = 1'b1;
			expected_ops.push_back(tail);
		end
	endtask

	always @(posedge clk) begin
		reorder_result_t seen;
		reorder_result_t want;
		if (arst_n) begin
			// results first: they belong to requests accepted earlier
			if (results.valid && results.ready) begin
				seen = {results.out_kind, results.out_code, results.line_number,
					results.column_number, results.last_of_run, results.region_split};
				checked_total++;
				if (expected_ops.size() == 0) begin
					fail_total++;
					if (fail_total <= REPORT_LIMIT)
						$display("%0t: unexpected result kind %0d code %h line %0d",
							$time, seen.kind, seen.code, seen.line,
							" col %0d last %b split %b", seen.column, seen.last,
							seen.split);
				end else begin
					want = expected_ops.pop_front();
					if (seen !== want) begin
						fail_total++;
						if (fail_total <= REPORT_LIMIT) begin
							$display("%0t: expected kind %0d code %h line %0d",
								$time, want.kind, want.code, want.line,
								" col %0d last %b split %b", want.column, want.last,
								want.split);
							$display("%0t: actual   kind %0d code %h line %0d",
								$time, seen.kind, seen.code, seen.line,
								" col %0d last %b split %b", seen.column, seen.last,
								seen.split);
						end
					end
				end
			end
			if (ops.valid && ops.ready)
				predict_request(ops.cmd, ops.op_kind, ops.char_code, ops.start_line);
			waiting = expected_ops.size();
		end
	end

endmodule
`default_nettype wire

FILE: tb/tb_diff_op_region_reorder_unit.sv
// Testbench top for the diff operation region reorder unit: clock, reset,
// request stimulus, result back-pressure and the verdict.
// Depends on dorr_pkg, dorr_if, the unit itself and dorr_reorder_checker.
`default_nettype none
module tb_diff_op_region_reorder_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import dorr_pkg::*;

	// codes the block must ignore
	localparam logic [CMD_BITS-1:0]  CMD_UNKNOWN  = 2'd3;
	localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 2'd3;

	localparam logic [CODE_BITS-1:0]  CODE_MAX  = 21'h10FFFF;
	localparam logic [START_BITS-1:0] START_MAX = '1;

	localparam int RANDOM_REQUESTS = 130;
	// longest flush: two passes over a full store plus the anchor, with margin
	localparam int DRAIN_CYCLES    = 100;

	logic clk;
	logic arst_n;

	dorr_in_if  ops ();
	dorr_out_if results ();

	int mismatches;
	int pending_results;
	int results_checked;

	int requests_sent = 0;
	int noise_sent    = 0;
	int hunks_opened  = 0;
	bit hunk_open     = 1'b0;
	// when set, neither side idles
	bit calm          = 1'b0;

	diff_op_region_reorder_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.ops     (ops),
		.results (results)
	);

	dorr_reorder_checker reorder_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.ops             (ops),
		.results         (results),
		.mismatches      (mismatches),
		.pending_results (pending_results),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Idle length in cycles: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	// Printable text most of the time; the whole code range otherwise.
	function automatic logic [CODE_BITS-1:0] pick_code();
		if ($urandom_range(0, 3) != 0)
			return CODE_BITS'($urandom_range(32, 126));
		return CODE_BITS'($urandom_range(0, CODE_MAX));
	endfunction

	// Offer one request from a falling edge and hold it until it is taken.
	// A random gap of idle cycles goes ahead of it unless the run is calm.
	task automatic issue_request(input logic [CMD_BITS-1:0] cmd,
		input logic [KIND_BITS-1:0] kind, input logic [CODE_BITS-1:0] code,
		input logic [START_BITS-1:0] start);
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			@(negedge clk);
			ops.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		ops.valid      <= 1'b1;
		ops.cmd        <= cmd;
		ops.op_kind    <= kind;
		ops.char_code  <= code;
		ops.start_line <= start;
		do @(posedge clk); while (!ops.ready);
		requests_sent++;
	endtask

	// Edit operation: start line is don't-care, so scramble it.
	task automatic edit_op(input logic [KIND_BITS-1:0] kind,
		input logic [CODE_BITS-1:0] code);
		issue_request(CMD_EDIT, kind, code, START_BITS'($urandom_range(0, START_MAX)));
	endtask

	task automatic open_hunk(input logic [START_BITS-1:0] start);
		issue_request(CMD_START, KIND_KEEP, pick_code(), start);
		hunk_open = 1'b1;
		hunks_opened++;
	endtask

	task automatic close_hunk();
		issue_request(CMD_END, KIND_KEEP, pick_code(),
			START_BITS'($urandom_range(0, START_MAX)));
		hunk_open = 1'b0;
	endtask

	// A request the block must ignore, chosen to suit whether a hunk is open.
	task automatic send_noise();
		case ($urandom_range(0, 2))
			0: issue_request(CMD_UNKNOWN, KIND_BITS'($urandom_range(0, 3)), pick_code(),
				START_BITS'($urandom_range(0, START_MAX)));
			1: edit_op(hunk_open ? KIND_UNKNOWN : KIND_BITS'($urandom_range(0, 3)),
				pick_code());
			default: begin
				if (hunk_open)
					edit_op(KIND_UNKNOWN, NEWLINE_CODE);
				else
					issue_request(CMD_END, KIND_BITS'($urandom_range(0, 3)), pick_code(),
						START_BITS'($urandom_range(0, START_MAX)));
			end
		endcase
		noise_sent++;
	endtask

	// Hold the sender off until every predicted result has come back.
	task automatic wait_results_drained();
		@(negedge clk);
		ops.valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
	endtask

	// Result back-pressure: bursts of ready with random stalls between them.
	initial begin
		int burst;
		int stall;
		results.ready = 1'b0;
		forever begin
			if (calm) begin
				results.ready <= 1'b1;
				@(negedge clk);
			end else begin
				results.ready <= 1'b1;
				burst = $urandom_range(1, 12);
				repeat (burst) @(negedge clk);
				stall = idle_len();
				if (stall > 0) begin
					results.ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
		end
	end

	// Watchdog: far beyond the slowest legal run under the longest stalls.
	initial begin
		#50_000_000;
		$display("diff_op_region_reorder_unit regression: fail");
		$finish;
	end

	initial begin
		int base;
		int segments;
		int run_len;
		bit force_long;
		int r;

		arst_n         = 1'b0;
		ops.valid      = 1'b0;
		ops.cmd        = CMD_START;
		ops.op_kind    = KIND_KEEP;
		ops.char_code  = '0;
		ops.start_line = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// ---- directed part ----
		// Outside a hunk: drop edits, ignore a stray hunk end and an unknown command.
		edit_op(KIND_KEEP, 21'h61);
		issue_request(CMD_END, KIND_KEEP, 21'h62, 24'd7);
		issue_request(CMD_UNKNOWN, KIND_UNKNOWN, CODE_MAX, START_MAX);
		// Start line zero is taken as it stands.
		open_hunk('0);
		edit_op(KIND_KEEP, CODE_MAX);
		// Mixed run closed by an inserted newline: deletes come out first.
		edit_op(KIND_DELETE, 21'h100000);
		edit_op(KIND_INSERT, 21'h0FFFFF);
		edit_op(KIND_DELETE, 21'h62);
		edit_op(KIND_INSERT, 21'h63);
		edit_op(KIND_INSERT, NEWLINE_CODE);
		// Unknown kind inside a hunk does nothing.
		edit_op(KIND_UNKNOWN, 21'h71);
		// Deleted newline is an anchor too.
		edit_op(KIND_DELETE, 21'h64);
		edit_op(KIND_DELETE, NEWLINE_CODE);
		edit_op(KIND_INSERT, 21'h65);
		edit_op(KIND_KEEP, '0);
		// Pending run flushed by a new hunk start at the old position.
		edit_op(KIND_INSERT, 21'h66);
		edit_op(KIND_DELETE, 21'h67);
		open_hunk(START_MAX);
		// Line already at its maximum: the newline must not wrap it.
		edit_op(KIND_KEEP, NEWLINE_CODE);
		edit_op(KIND_INSERT, 21'h68);
		issue_request(CMD_UNKNOWN, KIND_DELETE, 21'h69, 24'd3);
		// Run left open is flushed by hunk end.
		close_hunk();

		// ---- random part: well-formed hunks with random content and some noise ----
		base       = requests_sent - noise_sent;
		force_long = 1'b1;
		while ((requests_sent - noise_sent) - base < RANDOM_REQUESTS) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) == 0)
				send_noise();
			// Once, let everything in flight come out before carrying on.
			if (hunks_opened == 4)
				wait_results_drained();
			r = $urandom_range(0, 9);
			if (r == 0)
				open_hunk(START_MAX - START_BITS'($urandom_range(0, 2)));
			else if (r == 1)
				open_hunk(START_BITS'($urandom_range(1, START_MAX)));
			else
				open_hunk(START_BITS'($urandom_range(1, 500)));
			segments = $urandom_range(1, 5);
			for (int s = 0; s < segments; s++) begin
				// Now and then a run longer than the store, so it overflows.
				if (force_long || $urandom_range(0, 11) == 0)
					run_len = $urandom_range(REGION_DEPTH_DEF + 1, REGION_DEPTH_DEF + 8);
				else
					run_len = $urandom_range(0, 6);
				force_long = 1'b0;
				for (int j = 0; j < run_len; j++) begin
					if ($urandom_range(0, 19) == 0)
						send_noise();
					edit_op($urandom_range(0, 1) ? KIND_INSERT : KIND_DELETE, pick_code());
				end
				// Leave the last run without an anchor sometimes: hunk end flushes it.
				if (s < segments - 1 || $urandom_range(0, 2) != 0) begin
					if ($urandom_range(0, 2) == 0)
						edit_op(KIND_BITS'($urandom_range(0, 2)), NEWLINE_CODE);
					else
						edit_op(KIND_KEEP, pick_code());
				end
			end
			// Mostly close the hunk; otherwise the next start flushes it.
			if ($urandom_range(0, 4) != 0)
				close_hunk();
		end
		if (hunk_open)
			close_hunk();

		@(negedge clk);
		ops.valid <= 1'b0;
		calm = 1'b0;

		// Drain: wait for every predicted result, then watch for strays.
		while (pending_results != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d to be ignored) over %0d hunks",
			requests_sent, noise_sent, hunks_opened);
		$display("checked %0d results, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("diff_op_region_reorder_unit regression: pass");
		else
			$display("diff_op_region_reorder_unit regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
